/* hw/rtl/gpm_pkg.sv */
// Package for the glob pattern matcher: depths, character codes and class helpers.
`default_nettype none
package gpm_pkg;

   localparam int PAT_DEPTH = 256;
   localparam int SUBJ_DEPTH = 256;
   localparam int PAW = $clog2(PAT_DEPTH);
   localparam int PCW = $clog2(PAT_DEPTH + 1);
   localparam int PIW = PCW + 1;
   localparam int SAW = $clog2(SUBJ_DEPTH);
   localparam int SCW = $clog2(SUBJ_DEPTH + 1);
   localparam int SIW = SCW + 1;

   localparam logic [1:0] OP_PAT = 2'd0;
   localparam logic [1:0] OP_SUBJ = 2'd1;
   localparam logic [1:0] OP_RUN = 2'd2;
   localparam logic [1:0] OP_CLR = 2'd3;

   localparam int MB_FOLD = 0;
   localparam int MB_NOESC = 1;
   localparam int MB_PATH = 2;
   localparam int MB_PERIOD = 3;
   localparam int MB_LDIR = 4;

   localparam logic [7:0] CH_NUL = 8'h00;
   localparam logic [7:0] CH_STAR = 8'h2a;
   localparam logic [7:0] CH_QM = 8'h3f;
   localparam logic [7:0] CH_LBR = 8'h5b;
   localparam logic [7:0] CH_RBR = 8'h5d;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT = 8'h2e;
   localparam logic [7:0] CH_BSL = 8'h5c;
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_CARET = 8'h5e;
   localparam logic [7:0] CH_DASH = 8'h2d;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_EQ = 8'h3d;

   localparam logic [3:0] CLS_ALNUM = 4'd0;
   localparam logic [3:0] CLS_ALPHA = 4'd1;
   localparam logic [3:0] CLS_BLANK = 4'd2;
   localparam logic [3:0] CLS_CNTRL = 4'd3;
   localparam logic [3:0] CLS_DIGIT = 4'd4;
   localparam logic [3:0] CLS_GRAPH = 4'd5;
   localparam logic [3:0] CLS_LOWER = 4'd6;
   localparam logic [3:0] CLS_PRINT = 4'd7;
   localparam logic [3:0] CLS_PUNCT = 4'd8;
   localparam logic [3:0] CLS_SPACE = 4'd9;
   localparam logic [3:0] CLS_UPPER = 4'd10;
   localparam logic [3:0] CLS_XDIGIT = 4'd11;
   localparam logic [3:0] CLS_NONE = 4'd15;

   localparam logic [47:0] CLASS_NAME [12] = '{
      {"alnum", 8'h00}, {"alpha", 8'h00}, {"blank", 8'h00}, {"cntrl", 8'h00},
      {"digit", 8'h00}, {"graph", 8'h00}, {"lower", 8'h00}, {"print", 8'h00},
      {"punct", 8'h00}, {"space", 8'h00}, {"upper", 8'h00}, "xdigit"
   };
   localparam logic [2:0] CLASS_LEN [12] = '{
      3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6
   };

   function automatic logic is_up(input logic [7:0] c);
      return c >= 8'h41 && c <= 8'h5a;
   endfunction

   function automatic logic is_lo(input logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7a;
   endfunction

   function automatic logic is_dig(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [7:0] fold_char(input logic cf, input logic [7:0] c);
      return (cf && is_up(c)) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] to_up(input logic [7:0] c);
      return is_lo(c) ? c - 8'd32 : c;
   endfunction

   function automatic logic [7:0] swap_case(input logic [7:0] c);
      return is_up(c) ? c + 8'd32 : to_up(c);
   endfunction

   function automatic logic class_has(input logic [3:0] k, input logic [7:0] c);
      logic al;
      logic gr;
      al = is_up(c) || is_lo(c);
      gr = c >= 8'd33 && c <= 8'd126;
      case (k)
         CLS_ALNUM: return al || is_dig(c);
         CLS_ALPHA: return al;
         CLS_BLANK: return c == 8'h20 || c == 8'h09;
         CLS_CNTRL: return c < 8'd32 || c == 8'd127;
         CLS_DIGIT: return is_dig(c);
         CLS_GRAPH: return gr;
         CLS_LOWER: return is_lo(c);
         CLS_PRINT: return c >= 8'd32 && c <= 8'd126;
         CLS_PUNCT: return gr && !al && !is_dig(c);
         CLS_SPACE: return (c >= 8'd9 && c <= 8'd13) || c == 8'h20;
         CLS_UPPER: return is_up(c);
         default: return is_dig(c) || (c >= 8'h61 && c <= 8'h66) ||
                         (c >= 8'h41 && c <= 8'h46);
      endcase
   endfunction

   // nm holds the name bytes, first byte in the top octet
   function automatic logic [3:0] class_find(input logic [47:0] nm, input logic [2:0] len);
      logic [3:0] r;
      logic ok;
      r = CLS_NONE;
      for (int k = 11; k >= 0; k--) begin
         ok = (len == CLASS_LEN[k]);
         for (int i = 0; i < 6; i++) begin
            if (i < int'(len) && nm[47 - 8 * i -: 8] != CLASS_NAME[k][47 - 8 * i -: 8]) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            r = 4'(k);
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/glob_pattern_match_top.sv */
// Glob pattern matcher: pattern and subject stores with a sequenced backtracking matcher.
//
// Request channel (req_valid, req_stall, req_op, req_data_byte): op 0 appends a pattern
// byte, op 1 a subject byte, op 2 runs a match, op 3 clears the pattern. Zero bytes are
// ignored; bytes past a full store are dropped and flagged.
// Loads and clears give no result.
// A run gives one item on the response channel (rsp_valid, rsp_stall, rsp_matched,
// rsp_malformed, rsp_overflowed). Its latency depends on the data: every matcher step
// reloads a window of six pattern bytes and two subject bytes through the single read
// port of each store, then makes its decision; bracket classes and collating forms add
// a scan of the pattern, one byte at a time.
// Work is bounded by pattern length times subject length steps.
// req_stall is high while a run is in progress; a finished result waits in the
// output register while new loads are taken, and a run that finishes while the
// previous result is still stalled holds until it is taken.
// After a run the subject store is emptied; the pattern is kept.
// Write the mode register (csr_wr_en/csr_wr_data) only while idle; no check in the block.
// Synchronous reset empties both stores, clears the flags, the mode and rsp_valid.
`default_nettype none
module glob_pattern_match_top import gpm_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_matched,
   output logic            rsp_malformed,
   output logic            rsp_overflowed,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_WIN = 4'd1;
   localparam logic [3:0] ST_EVAL = 4'd2;
   localparam logic [3:0] ST_BACK = 4'd3;
   localparam logic [3:0] ST_BR_NEG = 4'd4;
   localparam logic [3:0] ST_BR_LOOP = 4'd5;
   localparam logic [3:0] ST_BR_RNG = 4'd6;
   localparam logic [3:0] ST_FP_A = 4'd7;
   localparam logic [3:0] ST_FP_B = 4'd8;
   localparam logic [3:0] ST_FP_C = 4'd9;
   localparam logic [3:0] ST_CLS = 4'd10;
   localparam logic [3:0] ST_DONE = 4'd11;

   logic [7:0] pmem [PAT_DEPTH];
   logic [7:0] smem [SUBJ_DEPTH];

   logic [3:0] state_ff, state_in, ret_ff, ret_in;
   logic [4:0] mode_ff, mode_in;
   logic [PCW-1:0] pcount_ff, pcount_in;
   logic [SCW-1:0] scount_ff, scount_in;
   logic pdrop_ff, pdrop_in, sdrop_ff, sdrop_in;
   logic [PIW-1:0] p_ff, p_in, sp_ff, sp_in, q_ff, q_in, fi_ff, fi_in, wbase_ff, wbase_in;
   logic [SIW-1:0] s_ff, s_in, ss_ff, ss_in, sbase_ff, sbase_in;
   logic star_ff, star_in, neg_ff, neg_in, hit_ff, hit_in, first_ff, first_in;
   logic fkind_ff, fkind_in;
   logic [7:0] fa_ff, fa_in, lo_ff, lo_in;
   logic [2:0] wk_ff, wk_in;
   logic res_m_ff, res_m_in, res_x_ff, res_x_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_m_ff, rsp_m_in, rsp_x_ff, rsp_x_in;
   logic rsp_o_ff, rsp_o_in;

   logic [7:0] w_ff [6];
   logic [7:0] x0_ff, x1_ff, d0_ff;
   logic [7:0] pd_ff, sd_ff;
   logic pv_ff, sv_ff;
   logic [7:0] pbv, sbv;
   logic [PIW-1:0] pa;
   logic [SIW-1:0] sa;
   logic accept, pwe, swe;
   logic cf, esc, path;
   logic [7:0] lc;

   function automatic logic lead_dot(input logic [4:0] md, input logic at_zero,
                                     input logic [7:0] xc, input logic [7:0] xp);
      return md[MB_PERIOD] && xc == CH_DOT && (at_zero || (md[MB_PATH] && xp == CH_SLASH));
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign pwe = accept && req_op == OP_PAT && req_data_byte != CH_NUL &&
                pcount_ff < PCW'(PAT_DEPTH);
   assign swe = accept && req_op == OP_SUBJ && req_data_byte != CH_NUL &&
                scount_ff < SCW'(SUBJ_DEPTH);
   assign cf = mode_ff[MB_FOLD];
   assign esc = !mode_ff[MB_NOESC];
   assign path = mode_ff[MB_PATH];
   assign lc = fold_char(cf, x0_ff);
   assign pbv = pv_ff ? pd_ff : CH_NUL;
   assign sbv = sv_ff ? sd_ff : CH_NUL;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_matched = rsp_m_ff;
   assign rsp_malformed = rsp_x_ff;
   assign rsp_overflowed = rsp_o_ff;

   always_comb begin
      case (state_ff)
         ST_WIN: pa = wbase_ff + PIW'(wk_ff);
         ST_FP_B: pa = fi_ff + PIW'(1);
         default: pa = fi_ff;
      endcase
      sa = (state_ff == ST_WIN && wk_ff == 3'd0) ? sbase_ff : sbase_ff - SIW'(1);
   end

   always_ff @(posedge clock) begin
      if (pwe) begin
         pmem[pcount_ff[PAW-1:0]] <= req_data_byte;
      end
      pd_ff <= pmem[pa[PAW-1:0]];
      pv_ff <= pa < {1'b0, pcount_ff};
   end

   always_ff @(posedge clock) begin
      if (swe) begin
         smem[scount_ff[SAW-1:0]] <= req_data_byte;
      end
      sd_ff <= smem[sa[SAW-1:0]];
      sv_ff <= sa < {1'b0, scount_ff};
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WIN && wk_ff != 3'd0) begin
         for (int i = 0; i < 5; i++) begin
            w_ff[i] <= w_ff[i + 1];
         end
         w_ff[5] <= pbv;
      end
      if (state_ff == ST_WIN && wk_ff == 3'd1) begin
         x0_ff <= sbv;
      end
      if (state_ff == ST_WIN && wk_ff == 3'd2) begin
         x1_ff <= sbv;
      end
      if (state_ff == ST_FP_B) begin
         d0_ff <= pbv;
      end
   end

   always_comb begin
      logic back_req, adv_req, win_req, fin_req, fin_m, fin_x, rhit;
      logic [PIW-1:0] adv_p, win_p, nq;
      logic [SIW-1:0] adv_s, win_s;
      logic [3:0] win_ret, k;
      logic [7:0] hi;
      logic [PIW-1:0] diff;

      back_req = 1'b0;
      adv_req = 1'b0;
      win_req = 1'b0;
      fin_req = 1'b0;
      fin_m = 1'b0;
      fin_x = 1'b0;
      rhit = 1'b0;
      adv_p = p_ff;
      adv_s = s_ff;
      win_p = p_ff;
      win_s = s_ff;
      win_ret = ST_EVAL;
      nq = q_ff;
      hi = CH_NUL;
      diff = fi_ff - (q_ff + PIW'(2));
      k = CLS_NONE;

      state_in = state_ff;
      ret_in = ret_ff;
      mode_in = mode_ff;
      pcount_in = pcount_ff;
      scount_in = scount_ff;
      pdrop_in = pdrop_ff;
      sdrop_in = sdrop_ff;
      p_in = p_ff;
      s_in = s_ff;
      sp_in = sp_ff;
      ss_in = ss_ff;
      q_in = q_ff;
      fi_in = fi_ff;
      wbase_in = wbase_ff;
      sbase_in = sbase_ff;
      star_in = star_ff;
      neg_in = neg_ff;
      hit_in = hit_ff;
      first_in = first_ff;
      fkind_in = fkind_ff;
      fa_in = fa_ff;
      lo_in = lo_ff;
      wk_in = wk_ff;
      res_m_in = res_m_ff;
      res_x_in = res_x_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_m_in = rsp_m_ff;
      rsp_x_in = rsp_x_ff;
      rsp_o_in = rsp_o_ff;

      if (csr_wr_en) begin
         mode_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_PAT: begin
                     if (pwe) begin
                        pcount_in = pcount_ff + PCW'(1);
                     end else if (req_data_byte != CH_NUL) begin
                        pdrop_in = 1'b1;
                     end
                  end
                  OP_SUBJ: begin
                     if (swe) begin
                        scount_in = scount_ff + SCW'(1);
                     end else if (req_data_byte != CH_NUL) begin
                        sdrop_in = 1'b1;
                     end
                  end
                  OP_RUN: begin
                     star_in = 1'b0;
                     adv_req = 1'b1;
                     adv_p = '0;
                     adv_s = '0;
                  end
                  OP_CLR: begin
                     pcount_in = '0;
                     pdrop_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_WIN: begin
            if (wk_ff == 3'd6) begin
               state_in = ret_ff;
            end else begin
               wk_in = wk_ff + 3'd1;
            end
         end
         ST_EVAL: begin
            if (lead_dot(mode_ff, s_ff == '0, x0_ff, x1_ff) && w_ff[0] != CH_DOT &&
                !(w_ff[0] == CH_BSL && esc && w_ff[1] == CH_DOT) && w_ff[0] != CH_NUL) begin
               back_req = 1'b1;
            end else if (w_ff[0] == CH_NUL) begin
               if (x0_ff == CH_NUL || (mode_ff[MB_LDIR] && x0_ff == CH_SLASH)) begin
                  fin_req = 1'b1;
                  fin_m = 1'b1;
               end else begin
                  back_req = 1'b1;
               end
            end else if (w_ff[0] == CH_STAR) begin
               star_in = 1'b1;
               sp_in = p_ff + PIW'(1);
               ss_in = s_ff;
               adv_req = 1'b1;
               adv_p = p_ff + PIW'(1);
               adv_s = s_ff;
            end else if (w_ff[0] == CH_QM) begin
               if (x0_ff == CH_NUL || (path && x0_ff == CH_SLASH)) begin
                  back_req = 1'b1;
               end else begin
                  adv_req = 1'b1;
                  adv_p = p_ff + PIW'(1);
                  adv_s = s_ff + SIW'(1);
               end
            end else if (w_ff[0] == CH_LBR) begin
               if (x0_ff == CH_NUL || (path && x0_ff == CH_SLASH)) begin
                  back_req = 1'b1;
               end else begin
                  q_in = p_ff + PIW'(1);
                  neg_in = 1'b0;
                  hit_in = 1'b0;
                  first_in = 1'b1;
                  win_req = 1'b1;
                  win_p = p_ff + PIW'(1);
                  win_ret = ST_BR_NEG;
               end
            end else if (w_ff[0] == CH_BSL && esc) begin
               if (w_ff[1] == CH_NUL) begin
                  fin_req = 1'b1;
                  fin_x = 1'b1;
               end else if (fold_char(cf, w_ff[1]) != lc || x0_ff == CH_NUL) begin
                  back_req = 1'b1;
               end else begin
                  adv_req = 1'b1;
                  adv_p = p_ff + PIW'(2);
                  adv_s = s_ff + SIW'(1);
               end
            end else if (fold_char(cf, w_ff[0]) == lc && x0_ff != CH_NUL) begin
               adv_req = 1'b1;
               adv_p = p_ff + PIW'(1);
               adv_s = s_ff + SIW'(1);
            end else begin
               back_req = 1'b1;
            end
         end
         ST_BACK: begin
            if (x0_ff == CH_NUL || (path && x0_ff == CH_SLASH) ||
                lead_dot(mode_ff, ss_ff == '0, x0_ff, x1_ff)) begin
               fin_req = 1'b1;
            end else begin
               ss_in = ss_ff + SIW'(1);
               adv_req = 1'b1;
               adv_p = sp_ff;
               adv_s = ss_ff + SIW'(1);
            end
         end
         ST_BR_NEG: begin
            if (w_ff[0] == CH_BANG || w_ff[0] == CH_CARET) begin
               neg_in = 1'b1;
               q_in = q_ff + PIW'(1);
               win_req = 1'b1;
               win_p = q_ff + PIW'(1);
               win_ret = ST_BR_LOOP;
            end else begin
               state_in = ST_BR_LOOP;
            end
         end
         ST_BR_LOOP: begin
            if (!first_ff && w_ff[0] == CH_RBR) begin
               if (hit_ff != neg_ff) begin
                  adv_req = 1'b1;
                  adv_p = q_ff + PIW'(1);
                  adv_s = s_ff + SIW'(1);
               end else begin
                  back_req = 1'b1;
               end
            end else begin
               first_in = 1'b0;
               if (w_ff[0] == CH_NUL) begin
                  if (x0_ff == CH_LBR) begin
                     adv_req = 1'b1;
                     adv_p = p_ff + PIW'(1);
                     adv_s = s_ff + SIW'(1);
                  end else begin
                     back_req = 1'b1;
                  end
               end else if (w_ff[0] == CH_LBR && (w_ff[1] == CH_DOT || w_ff[1] == CH_EQ)) begin
                  fa_in = w_ff[1];
                  fkind_in = 1'b0;
                  fi_in = q_ff + PIW'(2);
                  state_in = ST_FP_A;
               end else if (w_ff[0] == CH_LBR && w_ff[1] == CH_COLON) begin
                  fa_in = CH_COLON;
                  fkind_in = 1'b1;
                  fi_in = q_ff + PIW'(2);
                  state_in = ST_FP_A;
               end else begin
                  if (w_ff[0] == CH_BSL && esc && w_ff[1] != CH_NUL) begin
                     lo_in = w_ff[1];
                     nq = q_ff + PIW'(2);
                  end else begin
                     lo_in = w_ff[0];
                     nq = q_ff + PIW'(1);
                  end
                  q_in = nq;
                  win_req = 1'b1;
                  win_p = nq;
                  win_ret = ST_BR_RNG;
               end
            end
         end
         ST_BR_RNG: begin
            if (w_ff[0] == CH_DASH && w_ff[1] != CH_NUL && w_ff[1] != CH_RBR) begin
               if (w_ff[1] == CH_BSL && esc && w_ff[2] != CH_NUL) begin
                  hi = w_ff[2];
                  nq = q_ff + PIW'(3);
               end else begin
                  hi = w_ff[1];
                  nq = q_ff + PIW'(2);
               end
               rhit = (lo_ff <= x0_ff && x0_ff <= hi) ||
                      (cf && fold_char(cf, lo_ff) <= lc && lc <= fold_char(cf, hi)) ||
                      (cf && lo_ff <= to_up(x0_ff) && to_up(x0_ff) <= hi);
            end else begin
               rhit = fold_char(cf, lo_ff) == lc;
            end
            if (rhit) begin
               hit_in = 1'b1;
            end
            q_in = nq;
            win_req = 1'b1;
            win_p = nq;
            win_ret = ST_BR_LOOP;
         end
         ST_FP_A: begin
            if (fi_ff + PIW'(1) >= {1'b0, pcount_ff}) begin
               fin_req = 1'b1;
               fin_x = 1'b1;
            end else begin
               state_in = ST_FP_B;
            end
         end
         ST_FP_B: begin
            state_in = ST_FP_C;
         end
         ST_FP_C: begin
            if (d0_ff == fa_ff && pbv == CH_RBR) begin
               if (!fkind_ff) begin
                  if (fi_ff == q_ff + PIW'(3) && fold_char(cf, w_ff[2]) == lc) begin
                     hit_in = 1'b1;
                  end
                  q_in = fi_ff + PIW'(2);
                  win_req = 1'b1;
                  win_p = fi_ff + PIW'(2);
                  win_ret = ST_BR_LOOP;
               end else begin
                  win_req = 1'b1;
                  win_p = q_ff + PIW'(2);
                  win_ret = ST_CLS;
               end
            end else begin
               fi_in = fi_ff + PIW'(1);
               state_in = ST_FP_A;
            end
         end
         ST_CLS: begin
            if (diff < PIW'(7)) begin
               k = class_find({w_ff[0], w_ff[1], w_ff[2], w_ff[3], w_ff[4], w_ff[5]},
                              diff[2:0]);
            end
            if (k == CLS_NONE) begin
               fin_req = 1'b1;
               fin_x = 1'b1;
            end else begin
               if (class_has(k, x0_ff) || (cf && (is_up(x0_ff) || is_lo(x0_ff)) &&
                                           class_has(k, swap_case(x0_ff)))) begin
                  hit_in = 1'b1;
               end
               q_in = fi_ff + PIW'(2);
               win_req = 1'b1;
               win_p = fi_ff + PIW'(2);
               win_ret = ST_BR_LOOP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_o_in = pdrop_ff || sdrop_ff;
               rsp_m_in = res_m_ff && !(pdrop_ff || sdrop_ff);
               rsp_x_in = res_x_ff;
               scount_in = '0;
               sdrop_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (back_req) begin
         if (!star_ff) begin
            fin_req = 1'b1;
         end else begin
            win_req = 1'b1;
            win_p = sp_ff;
            win_s = ss_ff;
            win_ret = ST_BACK;
         end
      end
      if (adv_req) begin
         p_in = adv_p;
         s_in = adv_s;
         win_req = 1'b1;
         win_p = adv_p;
         win_s = adv_s;
         win_ret = ST_EVAL;
      end
      if (win_req) begin
         wbase_in = win_p;
         sbase_in = win_s;
         ret_in = win_ret;
         wk_in = 3'd0;
         state_in = ST_WIN;
      end
      if (fin_req) begin
         res_m_in = fin_m;
         res_x_in = fin_x;
         state_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= '0;
         pcount_ff <= '0;
         scount_ff <= '0;
         pdrop_ff <= 1'b0;
         sdrop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         pcount_ff <= pcount_in;
         scount_ff <= scount_in;
         pdrop_ff <= pdrop_in;
         sdrop_ff <= sdrop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;
      p_ff <= p_in;
      s_ff <= s_in;
      sp_ff <= sp_in;
      ss_ff <= ss_in;
      q_ff <= q_in;
      fi_ff <= fi_in;
      wbase_ff <= wbase_in;
      sbase_ff <= sbase_in;
      star_ff <= star_in;
      neg_ff <= neg_in;
      hit_ff <= hit_in;
      first_ff <= first_in;
      fkind_ff <= fkind_in;
      fa_ff <= fa_in;
      lo_ff <= lo_in;
      wk_ff <= wk_in;
      res_m_ff <= res_m_in;
      res_x_ff <= res_x_in;
      rsp_m_ff <= rsp_m_in;
      rsp_x_ff <= rsp_x_in;
      rsp_o_ff <= rsp_o_in;
   end

endmodule
`default_nettype wire
